### hdl/fsf_pkg.sv
// Shared types and constants for the folded symmetric FIR.
// Holds the controller state type and the command/status bundles
// that pass between fsf_ctrl and fsf_datapath. No dependencies.
package fsf_pkg;

  // Fixed port widths
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int COEF_IDX_W = 5;
  // Widest supported internal sample
  localparam int MAX_DATA_W = 24;

  // Command codes carried by each input beat
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_FILTER = 1'b1;

  // Cycles from the last issued pair until the accumulator is final
  localparam int DRAIN_CYCLES = 3;
  localparam int DRAIN_W      = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } fsf_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_coef;
    logic push_sample;
    logic issue;
    logic out_load;
  } fsf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_issue;
  } fsf_stat_t;

endpackage

### hdl/fsf_ctrl.sv
// Sequencer for the folded symmetric FIR: input and result handshakes,
// the tap sweep, pipeline drain and hand-off to the output register.
// Depends on fsf_pkg.
module fsf_ctrl import fsf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_command,
  output logic      out_valid,
  input  logic      out_ready,
  input  fsf_stat_t stat,
  output fsf_cmd_t  cmd
);

  fsf_state_t         state_r, state_nxt;
  logic [DRAIN_W-1:0] drain_r, drain_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               drain_last;

  assign drain_last = (drain_r == DRAIN_W'(DRAIN_CYCLES - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    drain_nxt = drain_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_command == CMD_FILTER)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        drain_nxt = '0;
        if (stat.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + DRAIN_W'(1);
        if (drain_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.load_coef   = in_valid && (in_command == CMD_LOAD);
        cmd.push_sample = in_valid && (in_command == CMD_FILTER);
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_DONE: begin
        cmd.out_load = !out_valid_r || out_ready;
      end
      default: cmd = '0;
    endcase
  end

  // Hold the result beat until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A sample beat starts the tap sweep
  a_push_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_sample |=> (state_r == ST_RUN))
    else $error("sample beat did not start the sweep");

  // The sweep ends on the last pair
  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && stat.last_issue |=> (state_r == ST_DRAIN))
    else $error("sweep did not stop on the last pair");

  // A loaded result is offered on the next cycle
  a_load_offers: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result load not presented");

endmodule

### hdl/fsf_datapath.sv
// Datapath of the folded symmetric FIR: circular delay-line memory,
// coefficient memory, pre-adder, multiplier, accumulator, rounding and
// saturation, and the result register. Depends on fsf_pkg.
module fsf_datapath import fsf_pkg::*; #(
  parameter int TAPS       = 64,
  parameter int DATA_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fsf_cmd_t                   cmd,
  output fsf_stat_t                  stat,
  input  logic [COEF_IDX_W-1:0]      in_coef_index,
  input  logic signed [COEF_W-1:0]   in_coef_value,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_saturated
);

  localparam int HALF_TAPS = TAPS / 2;
  localparam int PTR_W     = $clog2(TAPS);
  localparam int FILL_W    = $clog2(TAPS + 1);
  localparam int IDX_W     = (HALF_TAPS > 1) ? $clog2(HALF_TAPS) : 1;
  localparam int PAIR_W    = DATA_WIDTH + 1;
  localparam int PROD_W    = PAIR_W + COEF_W;
  localparam int ACC_W     = PROD_W + $clog2(HALF_TAPS) + 1;
  localparam int Y_W       = ACC_W - 14;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TAPS - 1);
  localparam logic signed [ACC_W:0]   RND_HALF = (ACC_W + 1)'(2 ** 14);
  localparam logic signed [Y_W-1:0]   Y_HI = Y_W'((2 ** (DATA_WIDTH - 1)) - 1);
  localparam logic signed [Y_W-1:0]   Y_LO = ~Y_HI;

  // Storage
  logic signed [DATA_WIDTH-1:0] dly_mem  [TAPS];
  logic signed [COEF_W-1:0]     coef_mem [HALF_TAPS];
  logic [HALF_TAPS-1:0]         coef_vld_r, coef_vld_nxt;

  // Sweep control
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  pa_r, pa_nxt;
  logic [PTR_W-1:0]  pb_r, pb_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              v1_r, v2_r, v3_r;

  // Pipeline payload
  logic signed [DATA_WIDTH-1:0] rd_a_r, rd_b_r;
  logic signed [COEF_W-1:0]     rd_h_r;
  logic                         ok_a_r, ok_b_r, ok_h_r;
  logic signed [PAIR_W-1:0]     pair_r;
  logic signed [COEF_W-1:0]     h2_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [ACC_W-1:0]      acc_r;

  logic signed [SAMPLE_W-1:0]   out_sample_r;
  logic                         out_sat_r;

  logic [MAX_DATA_W-1:0]        sample_wide;
  logic signed [DATA_WIDTH-1:0] sample_dw;
  logic                         coef_idx_ok;
  logic [IDX_W-1:0]             coef_waddr;
  logic                         ok_a, ok_b;
  logic [FILL_W-1:0]            b_tap;
  logic signed [DATA_WIDTH-1:0] term_a, term_b;
  logic signed [ACC_W:0]        rnd;
  logic signed [Y_W-1:0]        y;
  logic                         sat_hi, sat_lo;
  logic signed [DATA_WIDTH-1:0] clip;
  logic signed [MAX_DATA_W-1:0] clip_ext;

  // Take the sample sign from bit DATA_WIDTH-1 of the zero-extended port
  assign sample_wide = MAX_DATA_W'($unsigned(in_sample_in));
  assign sample_dw   = $signed(sample_wide[DATA_WIDTH-1:0]);

  assign coef_idx_ok = (32'(in_coef_index) < 32'(HALF_TAPS));
  assign coef_waddr  = IDX_W'(in_coef_index);

  assign stat.last_issue = (idx_r == IDX_W'(HALF_TAPS - 1));

  // Taps older than the fill count read as zero
  assign b_tap = FILL_W'(TAPS - 1) - FILL_W'(idx_r);
  assign ok_a  = (FILL_W'(idx_r) < fill_r);
  assign ok_b  = (b_tap < fill_r);

  // Advance pointers and counters
  always_comb begin
    head_nxt     = head_r;
    pa_nxt       = pa_r;
    pb_nxt       = pb_r;
    fill_nxt     = fill_r;
    idx_nxt      = idx_r;
    coef_vld_nxt = coef_vld_r;
    if (cmd.load_coef && coef_idx_ok) begin
      coef_vld_nxt[coef_waddr] = 1'b1;
    end
    if (cmd.push_sample) begin
      head_nxt = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
      pa_nxt   = head_nxt;
      pb_nxt   = (head_nxt == PTR_LAST) ? '0 : head_nxt + PTR_W'(1);
      fill_nxt = (fill_r == FILL_W'(TAPS)) ? fill_r : fill_r + FILL_W'(1);
      idx_nxt  = '0;
    end else if (cmd.issue) begin
      pa_nxt  = (pa_r == '0) ? PTR_LAST : pa_r - PTR_W'(1);
      pb_nxt  = (pb_r == PTR_LAST) ? '0 : pb_r + PTR_W'(1);
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      pa_r       <= '0;
      pb_r       <= '0;
      fill_r     <= '0;
      idx_r      <= '0;
      coef_vld_r <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      pa_r       <= pa_nxt;
      pb_r       <= pb_nxt;
      fill_r     <= fill_nxt;
      idx_r      <= idx_nxt;
      coef_vld_r <= coef_vld_nxt;
      v1_r       <= cmd.issue;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
    end
  end

  // Delay-line memory: one write, two reads
  always_ff @(posedge clk) begin
    if (cmd.push_sample) begin
      dly_mem[head_nxt] <= sample_dw;
    end
    if (cmd.issue) begin
      rd_a_r <= dly_mem[pa_r];
      rd_b_r <= dly_mem[pb_r];
      ok_a_r <= ok_a;
      ok_b_r <= ok_b;
    end
  end

  // Coefficient memory
  always_ff @(posedge clk) begin
    if (cmd.load_coef && coef_idx_ok) begin
      coef_mem[coef_waddr] <= in_coef_value;
    end
    if (cmd.issue) begin
      rd_h_r <= coef_mem[idx_r];
      ok_h_r <= coef_vld_r[idx_r];
    end
  end

  // Pre-add the symmetric pair
  assign term_a = ok_a_r ? rd_a_r : '0;
  assign term_b = ok_b_r ? rd_b_r : '0;

  always_ff @(posedge clk) begin
    pair_r <= PAIR_W'(term_a) + PAIR_W'(term_b);
    h2_r   <= ok_h_r ? rd_h_r : '0;
    prod_r <= pair_r * h2_r;
  end

  // Accumulate; clear on a new sample
  always_ff @(posedge clk) begin
    if (cmd.push_sample) begin
      acc_r <= '0;
    end else if (v3_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Round half up to Q15 and clip
  assign rnd    = (ACC_W + 1)'(acc_r) + RND_HALF;
  assign y      = $signed(rnd[ACC_W:15]);
  assign sat_hi = (y > Y_HI);
  assign sat_lo = (y < Y_LO);

  always_comb begin
    if (sat_hi) begin
      clip = DATA_WIDTH'(Y_HI);
    end else if (sat_lo) begin
      clip = DATA_WIDTH'(Y_LO);
    end else begin
      clip = y[DATA_WIDTH-1:0];
    end
  end

  assign clip_ext = MAX_DATA_W'(clip);

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_r <= $signed(clip_ext[SAMPLE_W-1:0]);
      out_sat_r    <= sat_hi || sat_lo;
    end
  end

  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

  // Fill count never passes the tap count
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(TAPS))
    else $error("delay-line fill count overran");

  // Accumulator only moves on a product or a new sample
  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !v3_r && !cmd.push_sample |=> $stable(acc_r))
    else $error("accumulator changed without a product");

endmodule

### hdl/folded_symmetric_fir.sv
// Folded symmetric FIR, linear phase, even tap count. A load beat
// (command 0) writes one Q1.15 half-coefficient and gives no result. A
// sample beat (command 1) pushes the sample into the delay line and
// gives one Q15 result, rounded half up and saturated, with a flag
// when clipped. One shared pre-adder and multiply-accumulate takes one
// symmetric pair a cycle from the two-read delay-line memory, behind a
// read, pre-add, multiply and accumulate pipeline. Items are processed
// one at a time; a waiting result sits in its own register, so the
// next beat is accepted while it waits. Coefficients and the delay
// line read as zero after reset without any clearing pass.
// Depends on fsf_pkg, fsf_ctrl and fsf_datapath.
module folded_symmetric_fir import fsf_pkg::*; #(
  parameter int TAPS       = 64,
  parameter int DATA_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_command,
  input  logic [COEF_IDX_W-1:0]      in_coef_index,
  input  logic signed [COEF_W-1:0]   in_coef_value,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_saturated
);

  fsf_cmd_t  cmd;
  fsf_stat_t stat;

  fsf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  fsf_datapath #(
    .TAPS       (TAPS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_coef_index  (in_coef_index),
    .in_coef_value  (in_coef_value),
    .in_sample_in   (in_sample_in),
    .out_sample_out (out_sample_out),
    .out_saturated  (out_saturated)
  );

endmodule

### sim/tb.sv
// Testbench for folded_symmetric_fir: random and directed load/sample beats with
// a scoreboard class that predicts each filtered sample and checks every result.
// Depends on fsf_pkg and the folded_symmetric_fir RTL under hdl/.
`timescale 1ns / 100ps

module tb;
  import fsf_pkg::*;

  localparam int FIR_TAPS    = 64;
  localparam int HALF_TAPS   = FIR_TAPS / 2;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sat;
  } fir_result_t;

  // Predicts the filter output and holds the results still owed by the block
  class fir_scoreboard;
    logic signed [SAMPLE_W-1:0] history[FIR_TAPS];
    logic signed [COEF_W-1:0]   half_coef[HALF_TAPS];
    fir_result_t                owed_q[$];
    int                         errors;

    function new();
      foreach (history[i]) history[i] = '0;
      foreach (half_coef[i]) half_coef[i] = '0;
      errors = 0;
    endfunction

    // Apply one accepted input beat; a sample beat queues its filtered result
    function void note_beat(logic cmd, logic [COEF_IDX_W-1:0] idx,
                            logic signed [COEF_W-1:0] coef,
                            logic signed [SAMPLE_W-1:0] samp);
      longint      acc;
      longint      y;
      fir_result_t r;
      if (cmd == CMD_LOAD) begin
        if (int'(idx) < HALF_TAPS) half_coef[idx] = coef;
        return;
      end
      for (int i = FIR_TAPS - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = samp;
      acc = 0;
      // Pre-add each symmetric pair, then multiply by its shared coefficient
      for (int i = 0; i < HALF_TAPS; i++)
        acc += (longint'(history[i]) + longint'(history[FIR_TAPS-1-i])) *
               longint'(half_coef[i]);
      // Round half up from Q30 to Q15, then clip to the sample range
      y = (acc + 64'sd16384) >>> 15;
      r.sat = 1'b0;
      if (y > 32767) begin
        y = 32767;
        r.sat = 1'b1;
      end else if (y < -32768) begin
        y = -32768;
        r.sat = 1'b1;
      end
      r.sample = y[SAMPLE_W-1:0];
      owed_q.push_back(r);
    endfunction

    // Compare one accepted result beat with the oldest owed result
    function void check_result(logic signed [SAMPLE_W-1:0] got_sample, logic got_sat);
      fir_result_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected result beat: sample_out %0d, saturated %0d",
               got_sample, got_sat);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got_sample !== want.sample) begin
        $error("sample_out mismatch: expected %0d, actual %0d",
               $signed(want.sample), got_sample);
        errors++;
      end
      if (got_sat !== want.sat) begin
        $error("saturated mismatch: expected %0d, actual %0d", want.sat, got_sat);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_command;
  logic [COEF_IDX_W-1:0]      in_coef_index;
  logic signed [COEF_W-1:0]   in_coef_value;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_saturated;

  int            sender_idle_pct;
  int            receiver_stall_pct;
  int            cycle_count;
  fir_scoreboard sb;

  folded_symmetric_fir #(
    .TAPS       (FIR_TAPS),
    .DATA_WIDTH (SAMPLE_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_coef_index  (in_coef_index),
    .in_coef_value  (in_coef_value),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_saturated  (out_saturated)
  );

  always #4 clk = ~clk;

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= receiver_stall_pct);
  end

  // Check every result beat taken at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_sample_out, out_saturated);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one input beat, with random idle cycles ahead of it; returns at a falling edge
  task automatic send_beat(logic cmd, logic [COEF_IDX_W-1:0] idx,
                           logic [COEF_W-1:0] coef, logic [SAMPLE_W-1:0] samp);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_command    = cmd;
    in_coef_index = idx;
    in_coef_value = coef;
    in_sample_in  = samp;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(cmd, idx, coef, samp);
    @(negedge clk);
  endtask

  task automatic load_coef(int idx, int value);
    send_beat(CMD_LOAD, idx[COEF_IDX_W-1:0], value[COEF_W-1:0], SAMPLE_W'($urandom));
  endtask

  task automatic push_sample(int value);
    send_beat(CMD_FILTER, COEF_IDX_W'($urandom), COEF_W'($urandom),
              value[SAMPLE_W-1:0]);
  endtask

  // Hold the sender off until every owed result has come back
  task automatic drain_results();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Mostly sample beats, with coefficient reloads of small or full-scale values
  task automatic run_phase(int beats, int idle_pct, int stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (beats) begin
      if ($urandom_range(99) < 15) begin
        if ($urandom_range(1) == 0) load_coef($urandom_range(31), $urandom);
        else load_coef($urandom_range(31), int'($urandom_range(4095)) - 2048);
      end else begin
        push_sample($urandom);
      end
    end
    drain_results();
  endtask

  initial begin
    sb                 = new();
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_command         = CMD_LOAD;
    in_coef_index      = '0;
    in_coef_value      = '0;
    in_sample_in       = '0;
    out_ready          = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    cycle_count        = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero coefficients, rounding at both signs, extremes, clipping both ways
    push_sample(32767);
    load_coef(0, 1);
    push_sample(16384);
    push_sample(-16384);
    push_sample(-16385);
    push_sample(0);
    load_coef(0, 32767);
    load_coef(31, -32768);
    load_coef(1, 32767);
    push_sample(32767);
    push_sample(32767);
    push_sample(-32768);
    push_sample(-32768);
    drain_results();

    run_phase(135, 0, 0);
    run_phase(135, 84, 0);
    run_phase(135, 0, 84);
    run_phase(135, 11, 11);

    repeat (HALF_TAPS + 12) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
